### rtl/mocl_pkg.sv
// Shared types and the ordered opcode mask/match table for the 68000 opcode
// class and length decoder. No dependencies.
package mocl_pkg;

	localparam int TableLen = 72;
	localparam int IdxW     = 7;
	localparam int WordW    = 16;
	localparam int LenW     = 4;

	typedef enum logic [3:0] {
		K_MOVEB,
		K_MOVEL,
		K_MOVEW,
		K_BRANCH,
		K_IMMED,
		K_BITI,
		K_ONEOP,
		K_SONEOP,
		K_FIXED,
		K_MOVEM,
		K_LINK,
		K_SCC,
		K_QUICK,
		K_DYADIC,
		K_SHIFT
	} kind_t;

	typedef struct packed {
		logic [WordW-1:0] mask;
		logic [WordW-1:0] match;
		kind_t            kind;
	} dec_entry_t;

	// Result of the table search, handed to the length logic.
	typedef struct packed {
		logic            found;
		logic [IdxW-1:0] idx;
		kind_t           kind;
	} dec_hit_t;

	// First matching entry wins: order matters.
	localparam dec_entry_t [0:TableLen-1] DecTable = '{
		'{16'hF000, 16'h1000, K_MOVEB},  '{16'hF000, 16'h2000, K_MOVEL},
		'{16'hF000, 16'h3000, K_MOVEW},  '{16'hF000, 16'h6000, K_BRANCH},
		'{16'hFF00, 16'h0000, K_IMMED},  '{16'hFF00, 16'h0200, K_IMMED},
		'{16'hFF00, 16'h0400, K_IMMED},  '{16'hFF00, 16'h0600, K_IMMED},
		'{16'hFF00, 16'h0A00, K_IMMED},  '{16'hFF00, 16'h0C00, K_IMMED},
		'{16'hF100, 16'h0100, K_BITI},   '{16'hF800, 16'h0800, K_BITI},
		'{16'hFFC0, 16'h40C0, K_ONEOP},  '{16'hFF00, 16'h4000, K_SONEOP},
		'{16'hFF00, 16'h4200, K_SONEOP}, '{16'hFFC0, 16'h44C0, K_ONEOP},
		'{16'hFF00, 16'h4400, K_SONEOP}, '{16'hFFC0, 16'h46C0, K_ONEOP},
		'{16'hFF00, 16'h4600, K_SONEOP}, '{16'hFFC0, 16'h4800, K_ONEOP},
		'{16'hFFF8, 16'h4840, K_FIXED},  '{16'hFFC0, 16'h4840, K_ONEOP},
		'{16'hFFF8, 16'h4880, K_FIXED},  '{16'hFFF8, 16'h48C0, K_FIXED},
		'{16'hFB80, 16'h4880, K_MOVEM},  '{16'hFFC0, 16'h4AC0, K_ONEOP},
		'{16'hFF00, 16'h4A00, K_SONEOP}, '{16'hFFF0, 16'h4E40, K_FIXED},
		'{16'hFFF8, 16'h4E50, K_LINK},   '{16'hFFF8, 16'h4880, K_FIXED},
		'{16'hFFF8, 16'h48C0, K_FIXED},  '{16'hFFF8, 16'h4E58, K_FIXED},
		'{16'hFFF8, 16'h4E60, K_FIXED},  '{16'hFFF8, 16'h4E68, K_FIXED},
		'{16'hFFFF, 16'h4E70, K_FIXED},  '{16'hFFFF, 16'h4E71, K_FIXED},
		'{16'hFFFF, 16'h4E72, K_FIXED},  '{16'hFFFF, 16'h4E73, K_FIXED},
		'{16'hFFFF, 16'h4E75, K_FIXED},  '{16'hFFFF, 16'h4E76, K_FIXED},
		'{16'hFFFF, 16'h4E77, K_FIXED},  '{16'hFFC0, 16'h4E80, K_ONEOP},
		'{16'hFFC0, 16'h4EC0, K_ONEOP},  '{16'hF1C0, 16'h4180, K_ONEOP},
		'{16'hF1C0, 16'h41C0, K_ONEOP},  '{16'hF0C0, 16'h50C0, K_SCC},
		'{16'hF100, 16'h5000, K_QUICK},  '{16'hF100, 16'h5100, K_QUICK},
		'{16'hF000, 16'h7000, K_FIXED},  '{16'hF1C0, 16'h80C0, K_ONEOP},
		'{16'hF1C0, 16'h81C0, K_ONEOP},  '{16'hF1F0, 16'h8100, K_FIXED},
		'{16'hF000, 16'h8000, K_DYADIC}, '{16'hF1C0, 16'h91C0, K_DYADIC},
		'{16'hF130, 16'h9100, K_FIXED},  '{16'hF000, 16'h9000, K_DYADIC},
		'{16'hF1C0, 16'hB1C0, K_DYADIC}, '{16'hF138, 16'hB108, K_FIXED},
		'{16'hF100, 16'hB000, K_DYADIC}, '{16'hF100, 16'hB100, K_DYADIC},
		'{16'hF1C0, 16'hC0C0, K_ONEOP},  '{16'hF1C0, 16'hC1C0, K_ONEOP},
		'{16'hF1F8, 16'hC188, K_FIXED},  '{16'hF1F8, 16'hC148, K_FIXED},
		'{16'hF1F8, 16'hC140, K_FIXED},  '{16'hF1F0, 16'hC100, K_FIXED},
		'{16'hF000, 16'hC000, K_DYADIC}, '{16'hF1C0, 16'hD1C0, K_DYADIC},
		'{16'hF130, 16'hD100, K_FIXED},  '{16'hF000, 16'hD000, K_DYADIC},
		'{16'hF100, 16'hE000, K_SHIFT},  '{16'hF100, 16'hE100, K_SHIFT}
	};

endpackage

### rtl/m68000_opcode_class_and_length.sv
// Top level of the 68000 opcode class and length decoder: input register,
// table search, length logic and output register.
// Depends on mocl_pkg, mocl_match and mocl_len.

// Decodes one 16-bit 68000 opcode word per transaction: searches an ordered
// 72-entry mask/match table, reports the first matching entry, whether the
// opcode decoded with a valid size, and the full instruction length in bytes
// (2 to 10) including extension words. Throughput is one transaction per
// clock while the output side takes results. An accepted word passes
// through one input register and then one output register, with the
// table search and length logic between them, and is taken from the
// output register once the output side is ready. Backpressure from the output
// side holds the output register; a new word is still taken while a result
// waits as long as the input register is empty, and otherwise only when the
// input register drains into the output register in the same cycle. No
// match gives matched=0, entry_index=0, length 2; a size code of three in
// the sized classes gives matched=0 with the entry index kept and length 2.
// No configuration, no state beyond the pipeline.
module m68000_opcode_class_and_length (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] opcode_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [6:0] entry_index, [10:7] length_bytes, [15:11] zero
	output logic        m_tuser   // [0] matched
);

	logic                        v_s1;
	logic [mocl_pkg::WordW-1:0]  word_s1;
	logic                        v_s2;
	logic                        matched_s2;
	logic [mocl_pkg::IdxW-1:0]   idx_s2;
	logic [mocl_pkg::LenW-1:0]   len_s2;

	mocl_pkg::dec_hit_t          hit;
	logic                        matched;
	logic [mocl_pkg::LenW-1:0]   length_bytes;
	logic                        adv_s2;
	logic                        adv_s1;

	// Output register frees up when empty or when its transaction is taken.
	assign adv_s2   = !v_s2 || m_tready;
	// Input register can take a word when it is empty or drains this cycle.
	assign adv_s1   = !v_s1 || adv_s2;
	assign s_tready = adv_s1;

	mocl_match u_match (
		.word (word_s1),
		.hit  (hit)
	);

	mocl_len u_len (
		.word         (word_s1),
		.hit          (hit),
		.matched      (matched),
		.length_bytes (length_bytes)
	);

	// Valid bits: reset clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Payload: load on advance, hold otherwise.
	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			word_s1 <= s_tdata;
		end
		if (adv_s2 && v_s1) begin
			matched_s2 <= matched;
			idx_s2     <= hit.found ? hit.idx : '0;
			len_s2     <= length_bytes;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tuser  = matched_s2;
	assign m_tdata  = {5'd0, len_s2, idx_s2};

endmodule

### rtl/mocl_match.sv
// Priority search of the opcode word against the ordered mask/match table.
// Depends on mocl_pkg.
module mocl_match (
	input  logic [mocl_pkg::WordW-1:0] word,
	output mocl_pkg::dec_hit_t         hit
);

	// All compares run in parallel; walk down so the lowest index is kept.
	always_comb begin
		hit.found = 1'b0;
		hit.idx   = '0;
		hit.kind  = mocl_pkg::K_FIXED;
		for (int i = mocl_pkg::TableLen - 1; i >= 0; i--) begin
			if ((word & mocl_pkg::DecTable[i].mask) == mocl_pkg::DecTable[i].match) begin
				hit.found = 1'b1;
				hit.idx   = mocl_pkg::IdxW'(i);
				hit.kind  = mocl_pkg::DecTable[i].kind;
			end
		end
	end

endmodule

### rtl/mocl_len.sv
// Instruction length and validity from the decode class and opcode bits.
// Depends on mocl_pkg.
module mocl_len (
	input  logic [mocl_pkg::WordW-1:0] word,
	input  mocl_pkg::dec_hit_t         hit,
	output logic                       matched,
	output logic [mocl_pkg::LenW-1:0]  length_bytes
);

	// Extension bytes of one effective address.
	function automatic logic [2:0] ea_ext(input logic [2:0] mode, input logic [2:0] rg,
		input logic is_long);
		logic [2:0] r;
		r = 3'd0;
		if (mode == 3'd5 || mode == 3'd6) begin
			r = 3'd2;
		end else if (mode == 3'd7) begin
			unique case (rg)
				3'd0, 3'd2, 3'd3: r = 3'd2;
				3'd1:             r = 3'd4;
				3'd4:             r = is_long ? 3'd4 : 3'd2;
				default:          r = 3'd0;
			endcase
		end
		return r;
	endfunction

	logic [1:0] sz;
	logic [2:0] opm;
	logic [2:0] ea_lo_w;
	logic [2:0] ea_lo_l;
	logic [2:0] ea_dst_w;
	logic [2:0] ea_dst_l;
	logic [2:0] ea_dya;
	logic [3:0] ext;
	logic       size_ok;

	assign sz       = word[7:6];
	assign opm      = word[8:6];
	assign ea_lo_w  = ea_ext(word[5:3], word[2:0], 1'b0);
	assign ea_lo_l  = ea_ext(word[5:3], word[2:0], 1'b1);
	assign ea_dst_w = ea_ext(word[8:6], word[11:9], 1'b0);
	assign ea_dst_l = ea_ext(word[8:6], word[11:9], 1'b1);
	assign ea_dya   = (opm == 3'd2 || opm == 3'd6 || opm == 3'd7) ? ea_lo_l : ea_lo_w;

	always_comb begin
		ext     = 4'd0;
		size_ok = 1'b1;
		unique case (hit.kind)
			mocl_pkg::K_MOVEB,
			mocl_pkg::K_MOVEW:  ext = {1'b0, ea_lo_w} + {1'b0, ea_dst_w};
			mocl_pkg::K_MOVEL:  ext = {1'b0, ea_lo_l} + {1'b0, ea_dst_l};
			mocl_pkg::K_BRANCH: ext = (word[7:0] == 8'd0) ? 4'd2 : 4'd0;
			mocl_pkg::K_IMMED: begin
				size_ok = (sz != 2'd3);
				ext     = (sz == 2'd2) ? 4'd4 + {1'b0, ea_lo_l} : 4'd2 + {1'b0, ea_lo_w};
			end
			mocl_pkg::K_BITI:   ext = (word[8] ? 4'd0 : 4'd2) + {1'b0, ea_lo_w};
			mocl_pkg::K_ONEOP,
			mocl_pkg::K_SCC:    ext = {1'b0, ea_lo_w};
			mocl_pkg::K_SONEOP,
			mocl_pkg::K_QUICK: begin
				size_ok = (sz != 2'd3);
				ext     = {1'b0, ea_lo_w};
			end
			mocl_pkg::K_MOVEM:  ext = 4'd2 + {1'b0, ea_lo_w};
			mocl_pkg::K_LINK:   ext = 4'd2;
			mocl_pkg::K_DYADIC: ext = {1'b0, ea_dya};
			mocl_pkg::K_SHIFT:  ext = (sz == 2'd3) ? {1'b0, ea_lo_w} : 4'd0;
			default:            ext = 4'd0;
		endcase
	end

	// No match or a bad size: bare opcode word.
	assign matched      = hit.found && size_ok;
	assign length_bytes = matched ? 4'd2 + ext : 4'd2;

endmodule

### rtl/mocl_checker.sv
// Port-level checks for the opcode class and length decoder, bound to the
// top level. Depends on m68000_opcode_class_and_length's port list only.
module mocl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	// A stalled result holds its valid and payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// An empty output stage never blocks the input.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	// Length stays within 2..10 and the index within the table.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[10:7] >= 4'd2 && m_tdata[10:7] <= 4'd10
			&& m_tdata[6:0] <= 7'd71 && m_tdata[15:11] == 5'd0)
		else $error("result out of range");

	// An undecoded word is just the opcode word.
	a_nomatch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[10:7] == 4'd2)
		else $error("unmatched word with extension");

	// An accepted word passes the input and output registers to the output if unstalled.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid ##1 m_tready |=> m_tvalid)
		else $error("result missing");

endmodule

bind m68000_opcode_class_and_length mocl_checker u_mocl_checker (.*);
